// File: src/quadratic_probe_hash_table_assert.svh
// Assertion macros for the hash table RTL; empty under synthesis.
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define QPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next
`define QPHT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define QPHT_ASSERT(lbl, prop, msg)
`define QPHT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: src/qpht_pkg.sv
// Types and constants for the quadratic probing hash table.
package qpht_pkg;

  localparam int unsigned TABLE_SIZE = 1021;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned HSUM_W     = 15;

  localparam logic [SLOT_W-1:0] LAST_SLOT       = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W:0]   TABLE_SIZE_EXT  = (SLOT_W + 1)'(TABLE_SIZE);
  localparam logic [CNT_W-1:0]  PROBE_LIMIT_RST = CNT_W'(1021);
  // First step of the offset sequence and its constant increment
  localparam logic [SLOT_W-1:0] DELTA_INIT      = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] DELTA_INC       = SLOT_W'(6);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_GONE  = 2'd2
  } tag_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FOUND = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    tag_e             tag;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// File: src/qpht_mem.sv
// Slot store: one write port and one registered read port.
module qpht_mem (
  input  logic              clk_i,
  input  qpht_pkg::mem_req_t req_i,
  output qpht_pkg::entry_t  rd_data_o
);
  import qpht_pkg::*;

  entry_t mem [TABLE_SIZE];
  entry_t rd_data_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem[req_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/qpht_modadd.sv
// Shared adder modulo the table size, for operands whose sum is below twice the size.
module qpht_modadd (
  input  logic [qpht_pkg::SLOT_W-1:0] a_i,
  input  logic [qpht_pkg::SLOT_W-1:0] b_i,
  output logic [qpht_pkg::SLOT_W-1:0] sum_o
);
  import qpht_pkg::*;

  logic [SLOT_W:0] raw;
  logic [SLOT_W:0] red;

  // add, then one conditional subtract
  always_comb begin
    raw   = {1'b0, a_i} + {1'b0, b_i};
    red   = raw - TABLE_SIZE_EXT;
    sum_o = (raw >= TABLE_SIZE_EXT) ? red[SLOT_W-1:0] : raw[SLOT_W-1:0];
  end

endmodule

// File: src/qpht_seq.sv
// Sequencer: clearing pass, key hashing, probe walk and result register.
`include "quadratic_probe_hash_table_assert.svh"

module qpht_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  qpht_pkg::cmd_e              in_cmd_i,
  input  logic [qpht_pkg::KEY_W-1:0]  in_key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output qpht_pkg::status_e           out_status_o,
  output logic [qpht_pkg::SLOT_W-1:0] out_slot_o,
  output logic [qpht_pkg::CNT_W-1:0]  out_count_o,
  input  logic [qpht_pkg::CNT_W-1:0]  probe_limit_i,
  output qpht_pkg::mem_req_t          mem_req_o,
  input  qpht_pkg::entry_t            mem_rd_i
);
  import qpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FOLD,
    S_READ,
    S_CHECK,
    S_STEP
  } state_e;

  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;
  cmd_e               cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [HSUM_W-1:0]  hsum_q, hsum_d;
  logic [SLOT_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0]  delta_q, delta_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [CNT_W-1:0]   out_count_q, out_count_d;

  logic [SLOT_W-1:0]  ma, mb, msum;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   cnt;
  logic               last_probe;
  logic               hit;
  logic               out_free;
  logic               fin;
  logic               fin_wr;
  tag_e               fin_tag;
  status_e            fin_status;
  logic [SLOT_W-1:0]  fin_slot;
  logic [CNT_W-1:0]   fin_count;
  mem_req_t           mreq;

  qpht_modadd u_modadd (
    .a_i   (ma),
    .b_i   (mb),
    .sum_o (msum)
  );

  // probe bookkeeping
  assign limit      = (probe_limit_i == '0) ? CNT_W'(1) : probe_limit_i;
  assign cnt        = idx_q + CNT_W'(1);
  assign last_probe = (cnt == limit);
  assign hit        = (mem_rd_i.tag == TAG_USED) && (mem_rd_i.key == key_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    hsum_d       = hsum_q;
    pos_d        = pos_q;
    delta_d      = delta_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    ma           = pos_q;
    mb           = delta_q;
    fin          = 1'b0;
    fin_wr       = 1'b0;
    fin_tag      = TAG_USED;
    fin_status   = ST_MISS;
    fin_slot     = '0;
    fin_count    = '0;
    mreq         = '0;
    mreq.rd_addr = pos_q;

    unique case (state_q)
      S_CLEAR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = clr_q;
        mreq.wr_data = '{tag: TAG_EMPTY, key: '0};
        clr_d        = clr_q + SLOT_W'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_cmd_i;
          key_d   = in_key_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        // 2^10 = 3 and 2^20 = 9 modulo the table size
        hsum_d = (HSUM_W'(key_q[30:20]) << 3) + HSUM_W'(key_q[30:20])
               + (HSUM_W'(key_q[19:10]) << 1) + HSUM_W'(key_q[19:10])
               + HSUM_W'(key_q[9:0]);
        if (cmd_q == CMD_NOP) begin
          fin = 1'b1;
        end else begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        // second fold: low ten bits plus three times the rest
        ma      = hsum_q[SLOT_W-1:0];
        mb      = (SLOT_W'(hsum_q[HSUM_W-1:SLOT_W]) << 1) + SLOT_W'(hsum_q[HSUM_W-1:SLOT_W]);
        pos_d   = msum;
        delta_d = DELTA_INIT;
        idx_d   = '0;
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (mem_rd_i.tag != TAG_USED) begin
              fin = 1'b1; fin_wr = 1'b1; fin_tag = TAG_USED;
              fin_status = ST_DONE; fin_slot = pos_q; fin_count = cnt;
            end else if (last_probe) begin
              fin = 1'b1; fin_status = ST_FULL; fin_count = cnt;
            end
          end
          CMD_SEARCH: begin
            if (hit) begin
              fin = 1'b1; fin_status = ST_FOUND; fin_slot = pos_q; fin_count = cnt;
            end else if (mem_rd_i.tag == TAG_EMPTY || last_probe) begin
              fin = 1'b1; fin_status = ST_MISS; fin_count = cnt;
            end
          end
          default: begin
            if (hit) begin
              fin = 1'b1; fin_wr = 1'b1; fin_tag = TAG_GONE;
              fin_status = ST_DONE; fin_slot = pos_q; fin_count = cnt;
            end else if (last_probe) begin
              fin = 1'b1; fin_status = ST_MISS; fin_count = cnt;
            end
          end
        endcase
        if (!fin) begin
          pos_d   = msum;
          idx_d   = cnt;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        // read issues at the new slot while the step grows by six
        ma      = delta_q;
        mb      = DELTA_INC;
        delta_d = msum;
        state_d = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // result register
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fin && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = fin_status;
      out_slot_d   = fin_slot;
      out_count_d  = fin_count;
      state_d      = S_IDLE;
      if (fin_wr) begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = pos_q;
        mreq.wr_data = '{tag: fin_tag, key: key_q};
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cmd_q        <= CMD_INSERT;
      key_q        <= '0;
      hsum_q       <= '0;
      pos_q        <= '0;
      delta_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
      out_slot_q   <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cmd_q        <= cmd_d;
      key_q        <= key_d;
      hsum_q       <= hsum_d;
      pos_q        <= pos_d;
      delta_q      <= delta_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_count_q  <= out_count_d;
    end
  end

  assign mem_req_o    = mreq;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_count_o  = out_count_q;

  `QPHT_ASSERT(a_wr_addr_range, !mem_req_o.wr_en || mem_req_o.wr_addr <= LAST_SLOT, "write beyond table")
  `QPHT_ASSERT(a_probe_range, state_q != S_CHECK || (pos_q <= LAST_SLOT && delta_q <= LAST_SLOT), "probe slot or step out of range")
  `QPHT_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, state_q == S_HASH, "word accepted but hashing not started")
  `QPHT_ASSERT_NEXT(a_write_source, mem_req_o.wr_en && state_q != S_CLEAR, out_valid_o, "table written without a result")

endmodule

// File: src/quadratic_probe_hash_table.sv
// Top level of the open-addressed hash table with quadratic probing.
//
// Input channel s_axis: tuser carries the command (insert, search, delete,
// no-op), tdata the 31-bit key. Output channel m_axis: tuser carries the
// status, tdata the slot (bits 9:0) and the probe count (bits 19:10).
// One result word per input word. The probe limit is written through
// cfg_wr_en_i / cfg_wr_data_i; the user must write it only while the block
// is idle, which the block itself does not enforce. Zero acts as one. After
// reset a clearing pass marks all 1021 slots empty with s_axis_tready low.
// Each operation is hashed in a hash state and a fold state, then every
// probe is a memory read and a compare through the slot store (one write
// and one read port) and the shared modulo adder. The result appears in
// the same cycle in which the block is ready again. The no-op command
// answers from the hash state without probing. The result sits in an
// output register; the next word is accepted while it waits, but a
// finished operation holds until the receiver takes the previous result.
module quadratic_probe_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] slot, [19:10] probe_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_wr_en_i,
  input  logic [9:0]  cfg_wr_data_i
);
  import qpht_pkg::*;

  logic [CNT_W-1:0]  probe_limit_q;
  mem_req_t          mem_req;
  entry_t            mem_rd;
  status_e           out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_count;

  // probe limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_limit_q <= PROBE_LIMIT_RST;
    end else if (cfg_wr_en_i) begin
      probe_limit_q <= cfg_wr_data_i;
    end
  end

  qpht_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (cmd_e'(s_axis_tuser)),
    .in_key_i      (s_axis_tdata[KEY_W-1:0]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (out_status),
    .out_slot_o    (out_slot),
    .out_count_o   (out_count),
    .probe_limit_i (probe_limit_q),
    .mem_req_o     (mem_req),
    .mem_rd_i      (mem_rd)
  );

  qpht_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  // output word packing
  assign m_axis_tdata = {4'b0000, out_count, out_slot};
  assign m_axis_tuser = out_status;

endmodule
